### rtl/core/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg
// Shared types, codes and decode helpers for the S-record line checker.
// ----------------------------------------------------------------------------
`default_nettype none

package srec_pkg;

    // Character codes that steer the line parser.
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;

    // Line status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FORMAT   = 3'd1;
    localparam logic [2:0] ST_LENGTH   = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_COUNT    = 3'd4;
    localparam logic [2:0] ST_UNKNOWN  = 3'd5;

    // Result kinds.
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Record type digits with special meaning.
    localparam logic [3:0] TYPE_S0    = 4'd0;
    localparam logic [3:0] TYPE_S3    = 4'd3;
    localparam logic [3:0] TYPE_S5    = 4'd5;
    localparam logic [3:0] TYPE_S7    = 4'd7;
    localparam logic [3:0] TYPE_NONE  = 4'd10;

    localparam logic [7:0]  SUM_GOOD       = 8'hFF;
    localparam logic [7:0]  COUNT_NO_DATA  = 8'd3;
    localparam logic [16:0] REC_COUNT_MAX  = 17'h1FFFF;

    // One result item.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [2:0]  status;
        logic [3:0]  rec_type;
        logic [31:0] address;
        logic [15:0] line_number;
        logic        no_data;
    } t_result;

    // Hex digit value; bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] f_hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        return v;
    endfunction

    // Number of address bytes for a record type; zero for unknown types.
    function automatic logic [2:0] f_addr_bytes(input logic [3:0] t);
        logic [2:0] n;
        case (t)
            4'd0, 4'd1, 4'd5, 4'd9: n = 3'd2;
            4'd2, 4'd8:             n = 3'd3;
            4'd3, 4'd7:             n = 3'd4;
            default:                n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/core/srec_line_core.sv
// ----------------------------------------------------------------------------
// srec_line_core
// Per-line parse state and the one-character decode step of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module srec_line_core
    import srec_pkg::*;
#(
    parameter int MAX_LINE_CHARS = 1023
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic [7:0] i_ch,
    input  wire logic    i_flush,
    output logic         o_res_valid,
    output t_result      o_res
);

    localparam int PW = $clog2(MAX_LINE_CHARS + 1);

    logic [PW-1:0] r_char_pos, n_char_pos;
    logic [7:0]    r_count_byte, n_count_byte;
    logic [3:0]    r_type_reg, n_type_reg;
    logic [7:0]    r_byte_sum, n_byte_sum;
    logic [31:0]   r_addr_acc, n_addr_acc;
    logic [3:0]    r_high_nibble, n_high_nibble;
    logic          r_format_bad, n_format_bad;
    logic          r_skip_to_lf, n_skip_to_lf;
    logic [15:0]   r_line_counter, n_line_counter;
    logic [16:0]   r_rec_count, n_rec_count;

    logic [4:0]    hex_raw;
    logic [3:0]    nib;
    logic [7:0]    byte_val;
    logic [PW-1:0] pos_m2;
    logic [PW-2:0] k;
    logic [2:0]    ab;
    logic          fmt_now;
    logic [PW-1:0] len_expect;
    logic [3:0]    fin_type;
    logic [2:0]    fin_status;
    logic          fin_no_data;
    logic          do_finish;
    logic [PW-2:0] idx_full;

    always_comb begin
        hex_raw    = f_hex_value(i_ch);
        nib        = hex_raw[4] ? 4'd0 : hex_raw[3:0];
        byte_val   = {r_high_nibble, nib};
        pos_m2     = r_char_pos - PW'(2);
        k          = pos_m2[PW-1:1];
        ab         = f_addr_bytes(r_type_reg);
        fmt_now    = r_format_bad | hex_raw[4];
        len_expect = PW'({r_count_byte, 1'b0}) + PW'(4);
        idx_full   = k - (PW-1)'(ab) - (PW-1)'(1);

        // Line judgment, first failing check wins.
        fin_type = (r_char_pos >= PW'(2)) ? r_type_reg : TYPE_NONE;
        if (r_format_bad || r_char_pos == '0) begin
            fin_status = ST_FORMAT;
        end else if (r_char_pos != len_expect) begin
            fin_status = ST_LENGTH;
        end else if (r_byte_sum != SUM_GOOD) begin
            fin_status = ST_CHECKSUM;
        end else if (fin_type == TYPE_S5 && {1'b0, r_addr_acc[15:0]} != r_rec_count) begin
            fin_status = ST_COUNT;
        end else if (f_addr_bytes(fin_type) == 3'd0) begin
            fin_status = ST_UNKNOWN;
        end else begin
            fin_status = ST_OK;
        end
        fin_no_data = (fin_status == ST_OK) &&
                      ((fin_type == TYPE_S0 && r_count_byte == COUNT_NO_DATA) ||
                       fin_type == TYPE_S5 || fin_type >= TYPE_S7);

        do_finish = i_flush ? (r_char_pos != '0 || r_skip_to_lf) : (i_ch == CH_LF);

        n_char_pos     = r_char_pos;
        n_count_byte   = r_count_byte;
        n_type_reg     = r_type_reg;
        n_byte_sum     = r_byte_sum;
        n_addr_acc     = r_addr_acc;
        n_high_nibble  = r_high_nibble;
        n_format_bad   = r_format_bad;
        n_skip_to_lf   = r_skip_to_lf;
        n_line_counter = r_line_counter;
        n_rec_count    = r_rec_count;

        o_res_valid       = 1'b0;
        o_res             = '0;
        o_res.address     = r_addr_acc;
        o_res.line_number = r_line_counter;

        if (do_finish) begin
            o_res_valid       = 1'b1;
            o_res.kind        = KIND_SUMMARY;
            o_res.status      = fin_status;
            o_res.rec_type    = fin_type;
            o_res.no_data     = fin_no_data;
            if (fin_status == ST_OK && fin_type >= 4'd1 && fin_type <= TYPE_S3 &&
                r_rec_count != REC_COUNT_MAX) begin
                n_rec_count = r_rec_count + 17'd1;
            end
            n_char_pos     = '0;
            n_count_byte   = '0;
            n_type_reg     = '0;
            n_byte_sum     = '0;
            n_addr_acc     = '0;
            n_high_nibble  = '0;
            n_format_bad   = 1'b0;
            n_skip_to_lf   = 1'b0;
            n_line_counter = r_line_counter + 16'd1;
        end else if (i_flush || r_skip_to_lf) begin
            // Nothing pending, or inside the ignored tail of a line.
        end else if (i_ch == CH_CR) begin
            n_skip_to_lf = 1'b1;
        end else if (r_char_pos < PW'(MAX_LINE_CHARS)) begin
            n_char_pos = r_char_pos + PW'(1);
            if (r_char_pos == PW'(0)) begin
                n_format_bad = r_format_bad | (i_ch != CH_S);
            end else if (r_char_pos == PW'(1)) begin
                n_type_reg = (i_ch >= CH_0 && i_ch <= CH_9) ? 4'(i_ch - CH_0) : TYPE_NONE;
            end else begin
                n_format_bad = fmt_now;
                if (!r_char_pos[0]) begin
                    n_high_nibble = nib;
                end else begin
                    n_byte_sum = r_byte_sum + byte_val;
                    if (k == '0) begin
                        n_count_byte = byte_val;
                    end else if (k <= (PW-1)'(ab)) begin
                        n_addr_acc = {r_addr_acc[23:0], byte_val};
                    end else if (!fmt_now && r_type_reg <= TYPE_S3 &&
                                 k < (PW-1)'(r_count_byte)) begin
                        o_res_valid       = 1'b1;
                        o_res.kind        = KIND_DATA;
                        o_res.data_byte   = byte_val;
                        o_res.byte_index  = idx_full[7:0];
                        o_res.rec_type    = r_type_reg;
                    end
                end
            end
        end

        if (!i_step) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_pos     <= '0;
            r_count_byte   <= '0;
            r_type_reg     <= '0;
            r_byte_sum     <= '0;
            r_addr_acc     <= '0;
            r_high_nibble  <= '0;
            r_format_bad   <= 1'b0;
            r_skip_to_lf   <= 1'b0;
            r_line_counter <= 16'd1;
            r_rec_count    <= '0;
        end else if (i_step) begin
            r_char_pos     <= n_char_pos;
            r_count_byte   <= n_count_byte;
            r_type_reg     <= n_type_reg;
            r_byte_sum     <= n_byte_sum;
            r_addr_acc     <= n_addr_acc;
            r_high_nibble  <= n_high_nibble;
            r_format_bad   <= n_format_bad;
            r_skip_to_lf   <= n_skip_to_lf;
            r_line_counter <= n_line_counter;
            r_rec_count    <= n_rec_count;
        end
    end

endmodule

`default_nettype wire

### rtl/core/srecord_line_checker.sv
// ----------------------------------------------------------------------------
// srecord_line_checker
// Streaming checker for Motorola S-record text, one character per transfer.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and never stalls on its own: each
// input transfer updates the running line state in the same cycle and loads
// at most one result into the output register, so an accepted character
// shows its result in the next cycle. The input is ready whenever the output
// register is empty or is being taken in that cycle, so a stalled output
// side stops the input after one held result. A line ends at LF, or at a
// transfer with the flush flag set when something is pending. A CR and
// everything after it up to the LF are ignored. Data bytes of S0 to S3
// records are sent as soon as they are decoded, before the checksum is
// known, so they are tentative; the line summary that follows carries the
// verdict (format, length, checksum, S5 count mismatch or unknown type),
// the record type, the address field and the line number. Characters past
// MAX_LINE_CHARS on one line are dropped and make the line fail the length
// check. The count of valid S1 to S3 lines saturates and is never cleared
// except by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module srecord_line_checker
    import srec_pkg::*;
#(
    parameter int MAX_LINE_CHARS = 1023
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input character stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] ch
    input  wire logic        i_s_tuser,   // [0] flush
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                          // [18:16] status, [22:19] rec_type,
                                          // [54:23] address, [70:55] line_number,
                                          // [71] no_data
    output logic             o_m_tuser    // [0] kind
);

    logic    s_xfer;
    logic    core_valid;
    t_result core_res;

    logic    r_out_valid;
    t_result r_out;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    srec_line_core #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_xfer),
        .i_ch        (i_s_tdata),
        .i_flush     (i_s_tuser),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    // Output register: reloaded on every input transfer, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_xfer) begin
            r_out_valid <= core_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer && core_valid) begin
            r_out <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {r_out.no_data, r_out.line_number, r_out.address,
                         r_out.rec_type, r_out.status, r_out.byte_index,
                         r_out.data_byte};

    // A tentative data byte always comes from an S0 to S3 record and never
    // carries a verdict.
    a_data_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_DATA) |->
        (r_out.status == ST_OK && !r_out.no_data && r_out.rec_type <= TYPE_S3))
        else $error("data byte with summary fields set");

    // The no-data flag is only raised on a passing summary.
    a_no_data_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.no_data) |->
        (r_out.kind == KIND_SUMMARY && r_out.status == ST_OK))
        else $error("no_data on a failed line");

    // A summary produced on an input transfer sits in the output register on
    // the next edge with the line number of the line it closed.
    a_summary_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && core_valid && core_res.kind == KIND_SUMMARY) |=>
        (r_out.line_number == $past(core_res.line_number) && r_out_valid))
        else $error("summary not captured");

endmodule

`default_nettype wire

### tb/tb_srecord_line_checker.sv
// ----------------------------------------------------------------------------
// tb_srecord_line_checker
// Self-checking testbench for the streaming S-record line checker.
// ----------------------------------------------------------------------------
// A short table of directed characters comes first. Some of its rows carry a
// line summary typed in by hand. Then one overlong line exercises the
// character limit, and about 900 random characters follow, mostly
// well-formed records with random content and occasional corruption, noise
// and odd line endings. Every accepted character goes through a local line
// model, and each result transfer from the block is compared field by field
// with the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_srecord_line_checker;
    import srec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LINE_LIMIT   = 514;
    localparam int         RANDOM_ITEMS = 900;
    localparam int         QUIET_AFTER  = 700;
    localparam int         LONG_HOLD    = 300;
    localparam logic [3:0] TYPE_S1      = 4'd1;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_LO_A      = 8'h61;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    // Block ports.
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] ch
    logic        i_s_tuser;    // [0] flush
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;    // [7:0] data_byte, [15:8] byte_index, [18:16] status,
                               // [22:19] rec_type, [54:23] address,
                               // [70:55] line_number, [71] no_data
    logic        o_m_tuser;    // [0] kind

    srecord_line_checker #(
        .MAX_LINE_CHARS(LINE_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Results predicted for accepted characters, oldest first.
    t_result pending_results[$];
    int      mismatches  = 0;
    int      items_sent  = 0;

    // Idling controls shared by the sender and the receiver processes.
    bit no_idle   = 1'b0;
    bit quiet     = 1'b0;
    bit in_random = 1'b0;

    // ------------------------------------------------------------------------
    // Line model. It keeps its own copy of the running line state and the
    // count of valid S1 to S3 lines, which only reset clears.
    // ------------------------------------------------------------------------
    logic [9:0]  ln_pos;
    logic [7:0]  ln_count;
    logic [3:0]  ln_type;
    logic [7:0]  ln_sum;
    logic [31:0] ln_addr;
    logic [3:0]  ln_high;
    logic        ln_fmt_bad;
    logic        ln_skip;
    logic [15:0] line_ctr;
    logic [16:0] good_data_lines;

    function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return {1'b0, 4'(c - CH_0)};
        if (c >= CH_UP_A && c <= CH_UP_A + 8'd5) return {1'b0, 4'(c - CH_UP_A + 8'd10)};
        if (c >= CH_LO_A && c <= CH_LO_A + 8'd5) return {1'b0, 4'(c - CH_LO_A + 8'd10)};
        return 5'h10;
    endfunction

    function automatic int addr_byte_count(input logic [3:0] t);
        case (t)
            4'd0, 4'd1, 4'd5, 4'd9: return 2;
            4'd2, 4'd8:             return 3;
            4'd3, 4'd7:             return 4;
            default:                return 0;
        endcase
    endfunction

    function automatic void clear_line_state();
        ln_pos     = '0;
        ln_count   = '0;
        ln_type    = '0;
        ln_sum     = '0;
        ln_addr    = '0;
        ln_high    = '0;
        ln_fmt_bad = 1'b0;
        ln_skip    = 1'b0;
    endfunction

    // Judges the pending line and builds its summary.
    function automatic t_result judge_line();
        t_result    r;
        logic [3:0] rtype;
        logic [2:0] st;
        r     = '0;
        rtype = (ln_pos >= 10'd2) ? ln_type : TYPE_NONE;
        if (ln_fmt_bad || ln_pos == '0) begin
            st = ST_FORMAT;
        end else if (int'(ln_pos) != 2 * int'(ln_count) + 4) begin
            st = ST_LENGTH;
        end else if (ln_sum != SUM_GOOD) begin
            st = ST_CHECKSUM;
        end else if (rtype == TYPE_S5 && {1'b0, ln_addr[15:0]} != good_data_lines) begin
            st = ST_COUNT;
        end else if (addr_byte_count(rtype) == 0) begin
            st = ST_UNKNOWN;
        end else begin
            st = ST_OK;
        end
        if (st == ST_OK) begin
            if (rtype != TYPE_S0 && rtype <= TYPE_S3 && good_data_lines != REC_COUNT_MAX) begin
                good_data_lines = good_data_lines + 17'd1;
            end
            r.no_data = (rtype == TYPE_S0 && ln_count == COUNT_NO_DATA) ||
                        rtype == TYPE_S5 || rtype >= TYPE_S7;
        end
        r.kind        = KIND_SUMMARY;
        r.status      = st;
        r.rec_type    = rtype;
        r.address     = ln_addr;
        r.line_number = line_ctr;
        clear_line_state();
        line_ctr = line_ctr + 16'd1;
        return r;
    endfunction

    // Advances the model by one accepted character; returns 1 with a result.
    function automatic bit predict_line_step(input logic [7:0] c, input logic fl,
                                             output t_result r);
        logic [9:0] p;
        logic [4:0] hv;
        logic [3:0] v;
        logic [7:0] b;
        int         k;
        int         ab;
        r = '0;
        if (fl) begin
            if (ln_pos != '0 || ln_skip) begin
                r = judge_line();
                return 1'b1;
            end
            return 1'b0;
        end
        if (c == CH_LF) begin
            r = judge_line();
            return 1'b1;
        end
        if (ln_skip) return 1'b0;
        if (c == CH_CR) begin
            ln_skip = 1'b1;
            return 1'b0;
        end
        p = ln_pos;
        if (int'(p) >= LINE_LIMIT) return 1'b0;
        ln_pos = p + 10'd1;
        if (p == 10'd0) begin
            if (c != CH_S) ln_fmt_bad = 1'b1;
            return 1'b0;
        end
        if (p == 10'd1) begin
            ln_type = (c >= CH_0 && c <= CH_9) ? 4'(c - CH_0) : TYPE_NONE;
            return 1'b0;
        end
        hv = hex_digit_value(c);
        if (hv[4]) begin
            ln_fmt_bad = 1'b1;
            v = 4'd0;
        end else begin
            v = hv[3:0];
        end
        if (!p[0]) begin
            ln_high = v;
            return 1'b0;
        end
        b      = {ln_high, v};
        k      = (int'(p) - 2) >> 1;
        ln_sum = ln_sum + b;
        ab     = addr_byte_count(ln_type);
        if (k == 0) begin
            ln_count = b;
            return 1'b0;
        end
        if (k <= ab) begin
            ln_addr = {ln_addr[23:0], b};
            return 1'b0;
        end
        if (!ln_fmt_bad && ln_type <= TYPE_S3 && k < int'(ln_count)) begin
            r.kind        = KIND_DATA;
            r.data_byte   = b;
            r.byte_index  = 8'(k - ab - 1);
            r.rec_type    = ln_type;
            r.address     = ln_addr;
            r.line_number = line_ctr;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. One character is offered per call; the model is advanced at
    // the edge where the transfer happens. A random gap may come first.
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic fl,
                             output bit has, output t_result r);
        if (!no_idle && !quiet && $urandom_range(0, 9) == 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tuser  <= fl;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        has = predict_line_step(c, fl, r);
        items_sent++;
    endtask

    task automatic feed_char(input logic [7:0] c, input logic fl);
        bit      has;
        t_result r;
        send_char(c, fl, has, r);
        if (has) pending_results.push_back(r);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_0 + 8'(n);
        return (($urandom_range(0, 3) == 0) ? CH_LO_A : CH_UP_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_LF);
        return c;
    endfunction

    // Builds one random record line, possibly damaged, and sends it.
    task automatic send_random_record();
        logic [7:0]  bytes_q[$];
        logic [7:0]  chars_q[$];
        logic [3:0]  t;
        logic [7:0]  type_ch;
        logic [31:0] addr;
        logic [7:0]  sum;
        int          ab;
        int          ndata;
        int          pick;
        int          bad;
        int          pos;
        int          term;

        pick = $urandom_range(0, 99);
        if (pick < 88) begin
            case ($urandom_range(0, 7))
                0: t = TYPE_S0;
                1: t = TYPE_S1;
                2: t = 4'd2;
                3: t = TYPE_S3;
                4: t = TYPE_S5;
                5: t = TYPE_S7;
                6: t = 4'd8;
                default: t = 4'd9;
            endcase
            type_ch = CH_0 + 8'(t);
        end else if (pick < 96) begin
            t       = ($urandom_range(0, 1) == 0) ? 4'd4 : 4'd6;
            type_ch = CH_0 + 8'(t);
        end else begin
            t       = TYPE_NONE;
            type_ch = 8'($urandom_range(8'h3A, 8'hFF));
        end

        ab = addr_byte_count(t);
        if (ab == 0) ab = 2;
        if (t <= TYPE_S3) begin
            ndata = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 254 - ab)
                                                 : $urandom_range(0, 8);
        end else if (t == TYPE_NONE || t == 4'd4 || t == 4'd6) begin
            ndata = $urandom_range(0, 4);
        end else begin
            ndata = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : 0;
        end

        case ($urandom_range(0, 9))
            0:       addr = 32'h0000_0000;
            1:       addr = 32'hFFFF_FFFF;
            default: addr = $urandom;
        endcase
        if (t == TYPE_S5 && $urandom_range(0, 4) != 0) begin
            addr = {16'h0000, good_data_lines[15:0]};
        end

        bad = $urandom_range(0, 99);
        bytes_q.push_back(8'(ab + ndata + 1));
        // A count off by one gives a length error with a good checksum.
        if (bad >= 6 && bad < 10) begin
            bytes_q[0] = ($urandom_range(0, 1) == 0) ? bytes_q[0] + 8'd1 : bytes_q[0] - 8'd1;
        end
        for (int i = ab - 1; i >= 0; i--) bytes_q.push_back(addr[8*i +: 8]);
        for (int i = 0; i < ndata; i++) bytes_q.push_back(8'($urandom));
        sum = '0;
        foreach (bytes_q[i]) sum = sum + bytes_q[i];
        bytes_q.push_back(~sum);
        if (bad < 6) bytes_q[bytes_q.size() - 1] ^= 8'(1 << $urandom_range(0, 7));

        chars_q.push_back(CH_S);
        chars_q.push_back(type_ch);
        foreach (bytes_q[i]) begin
            chars_q.push_back(hex_char(bytes_q[i][7:4]));
            chars_q.push_back(hex_char(bytes_q[i][3:0]));
        end
        pos = $urandom_range(2, chars_q.size() - 1);
        if (bad >= 10 && bad < 14) begin
            chars_q[pos] = 8'($urandom_range(8'h67, 8'h7E));
        end else if (bad >= 14 && bad < 17) begin
            chars_q[0] = 8'($urandom_range(8'h54, 8'hFF));
        end else if (bad >= 17 && bad < 20) begin
            chars_q.delete(pos);
        end

        foreach (chars_q[i]) feed_char(chars_q[i], 1'b0);

        term = $urandom_range(0, 99);
        if (term < 84) begin
            feed_char(CH_LF, 1'b0);
        end else if (term < 92) begin
            feed_char(CH_CR, 1'b0);
            repeat ($urandom_range(0, 3)) feed_char(any_but_lf(), 1'b0);
            if ($urandom_range(0, 1) == 0) feed_char(CH_LF, 1'b0);
            else feed_char(8'($urandom), 1'b1);
        end else begin
            feed_char(8'($urandom), 1'b1);
        end
    endtask

    // Random bytes of any value, or a lone flush with nothing pending.
    task automatic send_noise();
        if ($urandom_range(0, 2) == 0) begin
            feed_char(8'($urandom), 1'b1);
        end else begin
            repeat ($urandom_range(0, 12)) feed_char(8'($urandom), 1'b0);
            feed_char(CH_LF, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table. A row with typed set carries the summary expected for
    // it; other rows are predicted by the line model.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [7:0]  ch;
        logic        fl;
        logic        typed;
        logic [2:0]  st;
        logic [3:0]  rt;
        logic [31:0] addr;
        logic [15:0] ln;
        logic        nd;
    } t_dir_row;

    localparam int N_DIR = 23;
    t_dir_row dir_table [N_DIR];

    initial begin
        // Flush with nothing pending: no result at all.
        dir_table[0]  = '{8'h00,  1'b1, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        // Empty line.
        dir_table[1]  = '{CH_LF,  1'b0, 1'b1, ST_FORMAT, TYPE_NONE, 32'h0,    16'd1, 1'b0};
        // Line ended by a flush before its type digit.
        dir_table[2]  = '{"S",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[3]  = '{8'h5A,  1'b1, 1'b1, ST_LENGTH, TYPE_NONE, 32'h0,    16'd2, 1'b0};
        // A good S1 record with one data byte.
        dir_table[4]  = '{"S",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[5]  = '{"1",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[6]  = '{"0",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[7]  = '{"4",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[8]  = '{"1",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[9]  = '{"2",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[10] = '{"3",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[11] = '{"4",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[12] = '{"A",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[13] = '{"b",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[14] = '{"0",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[15] = '{"A",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[16] = '{CH_LF,  1'b0, 1'b1, ST_OK,     TYPE_S1,   32'h1234, 16'd3, 1'b0};
        // Non-digit type, a non-hex digit, then CR with trailing junk.
        dir_table[17] = '{"S",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[18] = '{"Z",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[19] = '{"g",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[20] = '{CH_CR,  1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[21] = '{"x",    1'b0, 1'b0, ST_OK,     4'd0,      32'h0,    16'd0, 1'b0};
        dir_table[22] = '{CH_LF,  1'b0, 1'b1, ST_FORMAT, TYPE_NONE, 32'h0,    16'd4, 1'b0};
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        bit      has;
        t_result r;
        t_result typed_sum;
        int      start_count;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'h00;
        i_s_tuser  <= 1'b0;
        clear_line_state();
        line_ctr        = 16'd1;
        good_data_lines = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) begin
            send_char(dir_table[i].ch, dir_table[i].fl, has, r);
            if (dir_table[i].typed) begin
                typed_sum             = '0;
                typed_sum.kind        = KIND_SUMMARY;
                typed_sum.status      = dir_table[i].st;
                typed_sum.rec_type    = dir_table[i].rt;
                typed_sum.address     = dir_table[i].addr;
                typed_sum.line_number = dir_table[i].ln;
                typed_sum.no_data     = dir_table[i].nd;
                pending_results.push_back(typed_sum);
            end else if (has) begin
                pending_results.push_back(r);
            end
        end

        // One line past the character limit: dropped characters, length error.
        feed_char(CH_S, 1'b0);
        feed_char(CH_0 + 8'd1, 1'b0);
        repeat (LINE_LIMIT + 8) feed_char(hex_char(4'($urandom)), 1'b0);
        feed_char(CH_LF, 1'b0);

        // Random part; the receiver takes its one long hold-off in here.
        in_random   = 1'b1;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            if (items_sent - start_count > QUIET_AFTER) quiet = 1'b1;
            if ($urandom_range(0, 99) < 6) send_noise();
            else send_random_record();
        end

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver ready. Short random stalls, one long hold-off early in the
    // random part so the output register fills and the input stalls, and no
    // stalls once the run has gone quiet.
    // ------------------------------------------------------------------------
    initial begin
        bit long_hold_done;
        long_hold_done = 1'b0;
        i_m_tready <= 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && in_random) begin
                long_hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (!no_idle && !quiet && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. A transfer happens at an edge where tvalid and tready
    // were both high just before it.
    // ------------------------------------------------------------------------
    task automatic report_field(input string name, input logic [31:0] e, input logic [31:0] a);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind        = o_m_tuser;
            got.data_byte   = o_m_tdata[7:0];
            got.byte_index  = o_m_tdata[15:8];
            got.status      = o_m_tdata[18:16];
            got.rec_type    = o_m_tdata[22:19];
            got.address     = o_m_tdata[54:23];
            got.line_number = o_m_tdata[70:55];
            got.no_data     = o_m_tdata[71];
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result transfer, expected none, actual 0x%0h",
                         $time, got);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                    report_field("kind", want.kind, got.kind);
                if (got.data_byte !== want.data_byte)
                    report_field("data_byte", want.data_byte, got.data_byte);
                if (got.byte_index !== want.byte_index)
                    report_field("byte_index", want.byte_index, got.byte_index);
                if (got.status !== want.status)
                    report_field("status", want.status, got.status);
                if (got.rec_type !== want.rec_type)
                    report_field("rec_type", want.rec_type, got.rec_type);
                if (got.address !== want.address)
                    report_field("address", want.address, got.address);
                if (got.line_number !== want.line_number)
                    report_field("line_number", want.line_number, got.line_number);
                if (got.no_data !== want.no_data)
                    report_field("no_data", want.no_data, got.no_data);
            end
        end
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
